[hw/rtl/oetb_pkg.sv]
// ----------------------------------------------------------------------------
// oetb_pkg
// Shared types, codes and defaults of the ordered expiry timer bank.
// ----------------------------------------------------------------------------
package oetb_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_FIRES_DEF = 64;

    localparam int ACT_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int PER_W   = 31;
    localparam int REM_W   = 34;
    localparam int OD_W    = 32;
    localparam int ENTRY_W = PER_W + REM_W;

    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ARM    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DISARM = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

endpackage

[hw/rtl/ordered_expiry_timer_bank_core.sv]
// ----------------------------------------------------------------------------
// ordered_expiry_timer_bank_core
// Bank of one-shot and periodic timer slots. A tick word subtracts the
// elapsed time from every alive slot and emits expired slots, most overdue
// first, ties to the lowest slot, capped per tick.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------
//   in       | in        | i_in_valid / o_in_stall | action slot period
//            |           |                        | periodic elapsed
//   out      | out       | o_out_valid / i_out_stall | fired_slot overdue
//            |           |                        | last backlog
//
// Arm, disarm and unknown words are taken in the idle state without a stall.
// A tick makes one pass per result plus a closing pass and can also wait on
// output stalls; each pass is one read sweep of the slot memory.
// Reset clears alive and periodic flags and all control state at once.
// A stalled output holds its word; the next word is prepared behind it.
// ----------------------------------------------------------------------------
module ordered_expiry_timer_bank_core
    import oetb_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_FIRES = MAX_FIRES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [PER_W-1:0]  i_period,
    input  logic              i_periodic,
    input  logic [PER_W-1:0]  i_elapsed,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [SLOT_W-1:0] o_fired_slot,
    output logic [OD_W-1:0]   o_overdue,
    output logic              o_last,
    output logic              o_backlog
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(MAX_FIRES + 1);

    t_state r_state, n_state;

    logic [ENTRY_W-1:0] r_mem [NUM_SLOTS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [NUM_SLOTS-1:0] r_alive;
    logic [NUM_SLOTS-1:0] r_periodic;

    logic [AW-1:0]  r_idx;
    logic           r_rd_vld;
    logic [AW-1:0]  r_rd_addr;
    logic           r_first;
    logic [PER_W-1:0] r_elapsed;
    logic [CW-1:0]  r_count;

    logic                    r_found;
    logic [AW-1:0]           r_best_idx;
    logic signed [REM_W-1:0] r_best_rem;
    logic [PER_W-1:0]        r_best_per;

    logic              r_pend_valid;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [OD_W-1:0]   r_pend_od;

    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic [OD_W-1:0]   r_out_od;
    logic              r_out_last;
    logic              r_out_backlog;

    logic in_take;
    logic slot_ok;
    logic [AW-1:0] in_addr;
    logic out_free;
    logic cap;
    logic rd_en;
    logic scan_start;
    logic dec_push;
    logic dec_last;
    logic dec_new;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic signed [REM_W-1:0] rd_rem;
    logic [PER_W-1:0]        rd_per;
    logic signed [REM_W:0]   diff;
    logic signed [REM_W-1:0] new_rem;
    logic                    cand;
    logic                    take;
    logic signed [REM_W:0]   neg;
    logic [OD_W-1:0]         best_od;
    logic signed [REM_W-1:0] reload_rem;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign slot_ok  = ({28'd0, i_slot} < 32'(NUM_SLOTS));
    assign in_addr  = AW'(i_slot);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cap      = (r_count == CW'(MAX_FIRES));

    // scan datapath
    assign rd_rem  = r_rd_data[REM_W-1:0];
    assign rd_per  = r_rd_data[ENTRY_W-1:REM_W];
    assign diff    = {rd_rem[REM_W-1], rd_rem} - {{(REM_W-PER_W+1){1'b0}}, r_elapsed};
    assign new_rem = (!r_first) ? rd_rem :
                     (diff[REM_W] != diff[REM_W-1]) ? {1'b1, {(REM_W-1){1'b0}}} :
                     diff[REM_W-1:0];
    assign cand    = r_rd_vld && r_alive[r_rd_addr] && (new_rem <= 0);
    assign take    = cand && (!r_found || (new_rem < r_best_rem));

    assign neg        = -{r_best_rem[REM_W-1], r_best_rem};
    assign best_od    = (neg[REM_W:OD_W] != '0) ? {OD_W{1'b1}} : neg[OD_W-1:0];
    assign reload_rem = r_best_rem + {{(REM_W-PER_W){1'b0}}, r_best_per};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_action == ACT_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == AW'(NUM_SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_found && !cap) begin
                    if (!r_pend_valid || out_free) begin
                        n_state = ST_SCAN;
                    end
                end else if (!r_pend_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        rd_en      = 1'b0;
        scan_start = 1'b0;
        dec_push   = 1'b0;
        dec_last   = 1'b0;
        dec_new    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_rd_addr;
        wr_data    = {rd_per, new_rem};
        case (r_state)
            ST_IDLE: begin
                if (in_take && i_action == ACT_TICK) begin
                    scan_start = 1'b1;
                end
                if (in_take && i_action == ACT_ARM && slot_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = in_addr;
                    wr_data = {i_period, {(REM_W-PER_W){1'b0}}, i_period};
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                wr_en = r_rd_vld && r_first && r_alive[r_rd_addr];
            end
            ST_DRAIN: begin
                wr_en = r_rd_vld && r_first && r_alive[r_rd_addr];
            end
            ST_DECIDE: begin
                if (r_found && !cap) begin
                    if (!r_pend_valid || out_free) begin
                        dec_push   = r_pend_valid;
                        dec_new    = 1'b1;
                        scan_start = 1'b1;
                        wr_en      = r_periodic[r_best_idx];
                        wr_addr    = r_best_idx;
                        wr_data    = {r_best_per, reload_rem};
                    end
                end else if (r_pend_valid && out_free) begin
                    dec_push = 1'b1;
                    dec_last = 1'b1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_alive      <= '0;
            r_periodic   <= '0;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_first      <= 1'b0;
            r_count      <= '0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (in_take && slot_ok && i_action == ACT_ARM) begin
                r_alive[in_addr]    <= 1'b1;
                r_periodic[in_addr] <= i_periodic;
            end
            if (in_take && slot_ok && i_action == ACT_DISARM) begin
                r_alive[in_addr] <= 1'b0;
            end
            if (in_take && i_action == ACT_TICK) begin
                r_first      <= 1'b1;
                r_count      <= '0;
                r_pend_valid <= 1'b0;
            end
            if (rd_en) begin
                r_idx <= r_idx + AW'(1);
            end
            if (scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (dec_new) begin
                r_first      <= 1'b0;
                r_count      <= r_count + CW'(1);
                r_pend_valid <= 1'b1;
                if (!r_periodic[r_best_idx]) begin
                    r_alive[r_best_idx] <= 1'b0;
                end
            end else if (dec_push) begin
                r_pend_valid <= 1'b0;
            end
            if (dec_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_idx;
        if (in_take && i_action == ACT_TICK) begin
            r_elapsed <= i_elapsed;
        end
        if (take) begin
            r_best_idx <= r_rd_addr;
            r_best_rem <= new_rem;
            r_best_per <= rd_per;
        end
        if (dec_new) begin
            r_pend_slot <= SLOT_W'(r_best_idx);
            r_pend_od   <= best_od;
        end
        if (dec_push) begin
            r_out_slot    <= r_pend_slot;
            r_out_od      <= r_pend_od;
            r_out_last    <= dec_last;
            r_out_backlog <= dec_last && r_found && cap;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_fired_slot = r_out_slot;
    assign o_overdue    = r_out_od;
    assign o_last       = r_out_last;
    assign o_backlog    = r_out_backlog;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FIRES))
        else $error("fire count beyond cap");

    a_backlog_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_backlog) |-> o_last)
        else $error("backlog without last");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && (r_count != '0)) |-> r_pend_valid)
        else $error("fired word lost during tick");

    a_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (r_state != ST_IDLE))
        else $error("tick ended without a last word");

endmodule

[dv/ordered_expiry_timer_bank_core_test.sv]
// ----------------------------------------------------------------------------
// ordered_expiry_timer_bank_core_test
// Self-checking bench for the timer bank: directed words for fire order, ties,
// re-arm, ignored words, zero periods, the fire cap and saturation, then
// random traffic with random sender gaps and output stalls. Every tick word is
// run through a local timer model and each fire word is checked in order.
// ----------------------------------------------------------------------------
module ordered_expiry_timer_bank_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import oetb_pkg::*;

    localparam int NUM_SLOTS = NUM_SLOTS_DEF;
    localparam int MAX_FIRES = MAX_FIRES_DEF;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [PER_W-1:0] PER_MAX = '1;
    localparam longint REM_FLOOR = -(longint'(1) <<< 33);
    localparam longint OD_CEIL = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [OD_W-1:0]   overdue;
        logic              last;
        logic              backlog;
    } t_fire;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [ACT_W-1:0]  i_action;
    logic [SLOT_W-1:0] i_slot;
    logic [PER_W-1:0]  i_period;
    logic              i_periodic;
    logic [PER_W-1:0]  i_elapsed;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [SLOT_W-1:0] o_fired_slot;
    logic [OD_W-1:0]   o_overdue;
    logic              o_last;
    logic              o_backlog;

    bit                      calm;
    int                      error_count;
    t_fire                   pending_fires[$];
    bit                      slot_live[NUM_SLOTS];
    bit                      slot_reload[NUM_SLOTS];
    logic [PER_W-1:0]        slot_interval[NUM_SLOTS];
    logic signed [REM_W-1:0] slot_left[NUM_SLOTS];

    ordered_expiry_timer_bank_core #(
        .NUM_SLOTS(NUM_SLOTS),
        .MAX_FIRES(MAX_FIRES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_slot      (i_slot),
        .i_period    (i_period),
        .i_periodic  (i_periodic),
        .i_elapsed   (i_elapsed),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_fired_slot(o_fired_slot),
        .o_overdue   (o_overdue),
        .o_last      (o_last),
        .o_backlog   (o_backlog)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("ordered_expiry_timer_bank_core_test: done, errors");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 38);
    end

    function automatic int most_overdue_slot();
        int best;
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i] && slot_left[i] <= 0) begin
                if (best < 0 || slot_left[i] < slot_left[best]) begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    function automatic void run_tick(logic [PER_W-1:0] elapsed);
        longint r;
        longint neg;
        int     s;
        int     n;
        t_fire  f;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_live[i]) begin
                r = longint'(slot_left[i]) - longint'(elapsed);
                slot_left[i] = (r < REM_FLOOR) ? REM_FLOOR : r;
            end
        end
        n = 0;
        s = most_overdue_slot();
        while (n < MAX_FIRES && s >= 0) begin
            neg = -longint'(slot_left[s]);
            f.slot = s[SLOT_W-1:0];
            f.overdue = (neg > OD_CEIL) ? '1 : neg[OD_W-1:0];
            if (slot_reload[s]) begin
                slot_left[s] = slot_left[s] + $signed({3'b000, slot_interval[s]});
            end else begin
                slot_live[s] = 1'b0;
            end
            n++;
            s = most_overdue_slot();
            f.last = (s < 0) || (n >= MAX_FIRES);
            f.backlog = (n >= MAX_FIRES) && (s >= 0);
            pending_fires = {pending_fires, f};
        end
    endfunction

    function automatic void apply_word(logic [ACT_W-1:0] action, logic [SLOT_W-1:0] slot,
                                       logic [PER_W-1:0] period, logic periodic,
                                       logic [PER_W-1:0] elapsed);
        case (action)
            ACT_ARM: begin
                if (slot < NUM_SLOTS) begin
                    slot_live[slot] = 1'b1;
                    slot_reload[slot] = periodic;
                    slot_interval[slot] = period;
                    slot_left[slot] = $signed({3'b000, period});
                end
            end
            ACT_DISARM: begin
                if (slot < NUM_SLOTS) begin
                    slot_live[slot] = 1'b0;
                end
            end
            ACT_TICK: begin
                run_tick(elapsed);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_word(logic [ACT_W-1:0] action, logic [SLOT_W-1:0] slot,
                             logic [PER_W-1:0] period, logic periodic,
                             logic [PER_W-1:0] elapsed);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= action;
        i_slot     <= slot;
        i_period   <= period;
        i_periodic <= periodic;
        i_elapsed  <= elapsed;
        do @(posedge i_clk); while (o_in_stall);
        apply_word(action, slot, period, periodic, elapsed);
    endtask

    task automatic wait_fires_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_fires.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_fire want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_fires.size() == 0) begin
                $error("fire word with none expected: slot %0d overdue %0d",
                       o_fired_slot, o_overdue);
                error_count++;
            end else begin
                want = pending_fires.pop_front();
                if (o_fired_slot !== want.slot) begin
                    $error("fired_slot: expected %0d, actual %0d", want.slot, o_fired_slot);
                    error_count++;
                end
                if (o_overdue !== want.overdue) begin
                    $error("overdue: expected %0d, actual %0d", want.overdue, o_overdue);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    error_count++;
                end
                if (o_backlog !== want.backlog) begin
                    $error("backlog: expected %0d, actual %0d", want.backlog, o_backlog);
                    error_count++;
                end
            end
        end
    end

    task automatic test_fire_order();
        send_word(ACT_ARM, 4'd0, 31'd10, 1'b0, 31'd0);
        send_word(ACT_ARM, 4'd15, 31'd3, 1'b1, PER_MAX);
        send_word(ACT_ARM, 4'd7, PER_MAX, 1'b1, 31'd0);
        send_word(ACT_TICK, 4'd15, PER_MAX, 1'b1, 31'd10);
        send_word(ACT_TICK, 4'd0, 31'd0, 1'b0, 31'd0);
        send_word(ACT_TICK, 4'd3, 31'd5, 1'b0, 31'd2);
        wait_fires_drained();
    endtask

    task automatic test_ties_and_rearm();
        send_word(ACT_ARM, 4'd3, 31'd5, 1'b0, 31'd0);
        send_word(ACT_ARM, 4'd9, 31'd8, 1'b0, 31'd0);
        send_word(ACT_ARM, 4'd9, 31'd5, 1'b1, 31'd0);
        send_word(ACT_DISARM, 4'd12, 31'd0, 1'b0, 31'd0);
        send_word(ACT_TICK, 4'd0, 31'd0, 1'b0, 31'd5);
        send_word(ACT_DISARM, 4'd9, 31'd0, 1'b0, 31'd0);
        send_word(ACT_TICK, 4'd0, 31'd0, 1'b0, 31'd20);
        wait_fires_drained();
    endtask

    task automatic test_ignored_words();
        send_word(ACT_ARM, 4'd1, 31'd1, 1'b0, 31'd0);
        send_word(ACT_UNUSED, 4'd15, PER_MAX, 1'b1, PER_MAX);
        send_word(ACT_TICK, 4'd1, 31'd1, 1'b1, 31'd0);
        send_word(ACT_TICK, 4'd1, 31'd1, 1'b1, 31'd1);
        wait_fires_drained();
    endtask

    task automatic test_cap_and_saturation();
        send_word(ACT_ARM, 4'd2, 31'd0, 1'b1, 31'd0);
        send_word(ACT_ARM, 4'd4, 31'd0, 1'b0, 31'd0);
        send_word(ACT_ARM, 4'd6, 31'd100, 1'b0, 31'd0);
        repeat (5) send_word(ACT_TICK, 4'd0, 31'd0, 1'b0, PER_MAX);
        send_word(ACT_DISARM, 4'd2, 31'd0, 1'b0, 31'd0);
        send_word(ACT_TICK, 4'd0, 31'd0, 1'b0, 31'd0);
        wait_fires_drained();
    endtask

    task automatic test_random_traffic(int count);
        int               done_words;
        int               roll;
        logic [ACT_W-1:0] action;
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] elapsed;
        done_words = 0;
        while (done_words < count) begin
            calm = (done_words < 40);
            roll = $urandom_range(99);
            action = (roll < 5) ? ACT_UNUSED : (roll < 40) ? ACT_TICK :
                     (roll < 85) ? ACT_ARM : ACT_DISARM;
            roll = $urandom_range(99);
            period = (roll < 3) ? 31'd0 : (roll < 13) ? 31'($urandom) :
                     31'($urandom_range(1, 60));
            roll = $urandom_range(99);
            elapsed = (roll < 10) ? 31'($urandom) : 31'($urandom_range(0, 40));
            send_word(action, 4'($urandom_range(NUM_SLOTS - 1)), period,
                      1'($urandom), elapsed);
            if (action != ACT_UNUSED) begin
                done_words++;
            end
        end
        calm = 1'b0;
        wait_fires_drained();
    endtask

    initial begin
        calm        = 1'b0;
        error_count = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_action    = ACT_TICK;
        i_slot      = '0;
        i_period    = '0;
        i_periodic  = 1'b0;
        i_elapsed   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_live[i]     = 1'b0;
            slot_reload[i]   = 1'b0;
            slot_interval[i] = '0;
            slot_left[i]     = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fire_order();
        test_ties_and_rearm();
        test_ignored_words();
        test_cap_and_saturation();
        test_random_traffic(120);

        repeat (4 * (NUM_SLOTS + 2)) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ordered_expiry_timer_bank_core_test: done, clean");
        end else begin
            $display("ordered_expiry_timer_bank_core_test: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/oetb_pkg.sv
hw/rtl/ordered_expiry_timer_bank_core.sv
dv/ordered_expiry_timer_bank_core_test.sv
